>>> rtl/bba_pkg.sv
// Shared types and constants for the block bitmap allocator.
// Used by the top level and its checker; no dependencies.
`timescale 1ns / 1ps

package bba_pkg;

  localparam int CFG_W      = 13;
  localparam int BLK_W      = 12;
  localparam int WORD_BITS  = 64;
  localparam int WORD_SHIFT = 6;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_NOFREE       = 2'd1,
    ST_ALREADY_FREE = 2'd2,
    ST_RANGE        = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ASCAN,
    S_FREE,
    S_DONE
  } state_t;

  typedef struct packed {
    opcode_t          opcode;
    logic [BLK_W-1:0] block_number;
  } in_word_t;

  typedef struct packed {
    logic [BLK_W-1:0] granted_block;
    status_t          status;
  } out_word_t;

endpackage

>>> rtl/block_bitmap_allocator_top.sv
// A free reads and updates the map word that holds its block; an allocate scans the
// 64-bit map words from word 0 for a free bit below the configured count. One word is
// in flight; the next waits until the result enters the output register (stalls delay it).
// The scan reads one map word per cycle from a single-port-read memory.
// Reset (rst_n low, synchronous): count set to 4096, then a clearing pass over all
// map words zeroes the map; no input word is accepted during it.
`timescale 1ns / 1ps

module block_bitmap_allocator_top
  import bba_pkg::*;
#(
  parameter int MAX_BLOCKS = 4096
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_word_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_word_t        out_data,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam int MAP_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int LWW       = CFG_W - WORD_SHIFT + 1;
  localparam int CMPW      = (AW + 1 > LWW) ? AW + 1 : LWW;
  localparam int CFG_MAX   = (1 << CFG_W) - 1;
  localparam logic [CFG_W-1:0] LIMIT_CAP =
    CFG_W'((MAX_BLOCKS > CFG_MAX) ? CFG_MAX : MAX_BLOCKS);

  state_t                 state_r, state_nxt;
  logic [CFG_W-1:0]       cfg_r;
  logic [AW-1:0]          clr_r, clr_nxt;
  logic [AW:0]            word_r, word_nxt;
  logic [AW-1:0]          chk_word_r, chk_word_nxt;
  logic                   chk_vld_r, chk_vld_nxt;
  logic [BLK_W-1:0]       blk_r, blk_nxt;
  out_word_t              res_r, res_nxt;
  logic                   out_valid_r, out_valid_nxt;
  out_word_t              out_data_r, out_data_nxt;

  logic [WORD_BITS-1:0]   mem [MAP_WORDS];
  logic [WORD_BITS-1:0]   rd_data_r;
  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  logic [AW-1:0]          mem_raddr;
  logic [WORD_BITS-1:0]   mem_wdata;

  logic [CFG_W-1:0]       limit;
  logic [CFG_W:0]         lim_sum;
  logic [LWW-1:0]         lim_words;
  logic [WORD_SHIFT-1:0]  rem;
  logic                   last_word;
  logic [WORD_BITS-1:0]   range_mask;
  logic [WORD_BITS-1:0]   avail;
  logic                   found;
  logic [WORD_SHIFT-1:0]  idx;
  logic                   in_acc;

  assign limit     = (cfg_r > LIMIT_CAP) ? LIMIT_CAP : cfg_r;
  assign lim_sum   = {1'b0, limit} + (CFG_W + 1)'(WORD_BITS - 1);
  assign lim_words = lim_sum[CFG_W:WORD_SHIFT];
  assign rem       = limit[WORD_SHIFT-1:0];
  assign last_word = (CMPW'(chk_word_r) + CMPW'(1)) == CMPW'(lim_words);
  assign range_mask = (last_word && rem != '0) ?
                      ((WORD_BITS'(1) << rem) - WORD_BITS'(1)) : '1;
  assign avail     = ~rd_data_r & range_mask;

  always_comb begin
    found = 1'b0;
    idx   = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (avail[i]) begin
        found = 1'b1;
        idx   = WORD_SHIFT'(i);
      end
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    word_nxt      = word_r;
    chk_word_nxt  = chk_word_r;
    chk_vld_nxt   = chk_vld_r;
    blk_nxt       = blk_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_waddr     = chk_word_r;
    mem_wdata     = rd_data_r;
    mem_raddr     = word_r[AW-1:0];
    case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '0;
        clr_nxt   = clr_r + AW'(1);
        if (clr_r == AW'(MAP_WORDS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        mem_raddr = (in_data.opcode == OP_FREE) ?
                    AW'(in_data.block_number >> WORD_SHIFT) : '0;
        if (in_acc) begin
          blk_nxt      = in_data.block_number;
          word_nxt     = (AW + 1)'(1);
          chk_word_nxt = '0;
          chk_vld_nxt  = (lim_words != '0);
          state_nxt    = (in_data.opcode == OP_FREE) ? S_FREE : S_ASCAN;
        end
      end
      S_ASCAN: begin
        word_nxt     = word_r + (AW + 1)'(1);
        chk_word_nxt = word_r[AW-1:0];
        chk_vld_nxt  = CMPW'(word_r) < CMPW'(lim_words);
        if (!chk_vld_r) begin
          res_nxt.granted_block = '0;
          res_nxt.status        = ST_NOFREE;
          state_nxt             = S_DONE;
        end else if (found) begin
          mem_we                = 1'b1;
          mem_wdata             = rd_data_r | (WORD_BITS'(1) << idx);
          res_nxt.granted_block = BLK_W'({chk_word_r, idx});
          res_nxt.status        = ST_OK;
          state_nxt             = S_DONE;
        end
      end
      S_FREE: begin
        mem_waddr             = AW'(blk_r >> WORD_SHIFT);
        res_nxt.granted_block = '0;
        if ({1'b0, blk_r} >= limit) begin
          res_nxt.status = ST_RANGE;
        end else if (!rd_data_r[blk_r[WORD_SHIFT-1:0]]) begin
          res_nxt.status = ST_ALREADY_FREE;
        end else begin
          mem_we         = 1'b1;
          mem_wdata      = rd_data_r & ~(WORD_BITS'(1) << blk_r[WORD_SHIFT-1:0]);
          res_nxt.status = ST_OK;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      cfg_r       <= CFG_W'(4096);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        cfg_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    word_r     <= word_nxt;
    chk_word_r <= chk_word_nxt;
    chk_vld_r  <= chk_vld_nxt;
    blk_r      <= blk_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
  end

endmodule

>>> rtl/bba_checker.sv
// Port-level checker for the block bitmap allocator, bound to the top level.
// Depends on bba_pkg for the word and status types.
`timescale 1ns / 1ps

module bba_checker
  import bba_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  a_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |-> out_data.granted_block == '0)
    else $error("nonzero block number on a failed request");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready && !$rose(out_valid))
    else $error("accepted a word or answered too early");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_ready)
    else $error("activity right after reset");

endmodule

bind block_bitmap_allocator_top bba_checker u_bba_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
